// ===== rtl/amdt_pkg.sv =====
// shared types and constants of the adjacency matrix degree tracker
`default_nettype none

package amdt_pkg;

    // field widths fixed by the item format
    localparam int VERTEX_W = 8;
    localparam int COUNT_W  = 8;

    // counters saturate at their all-ones value
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    // reset value of the vertex count register
    localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 8'd128;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // request held between the read and the writeback cycle
    typedef struct packed {
        logic                action;
        logic                ok;
        logic [VERTEX_W-1:0] src_m1;
        logic [VERTEX_W-1:0] dst_m1;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/amdt_edge_ram.sv =====
// edge bit memory: one row of destination bits per source vertex
`default_nettype none

module amdt_edge_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/amdt_count_ram.sv =====
// per-vertex degree counter memory
`default_nettype none

module amdt_count_ram
    import amdt_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [COUNT_W-1:0]       rdata,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [COUNT_W-1:0]       wdata
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/adjacency_matrix_degree_tracker.sv =====
// Directed graph adjacency matrix with per-vertex in- and out-degree counters.
//
// Requests arrive on the s_ stream: an insert sets edge (src,dst) and bumps
// both degrees once if the edge is new; a query returns both degrees of src.
// Every request gives exactly one response on the m_ stream. A src vertex, or
// for an insert a dst vertex, of 0 or above min(vertex_count, MAX_VERTICES)
// returns status 1 and changes nothing. The cfg channel writes vertex_count
// (8 bits); each write starts a new graph. One request is in flight at a time:
// the synchronous read of the edge row and both counters, then the writeback
// into the same memory ports and the load of the output register, and only
// then is the next request taken. The output register lets a request be taken
// while a response still waits; if m_tready stays low the writeback stage
// holds and s_tready stays low. After reset and after every cfg write a
// clearing pass zeroes one edge row and one counter pair per cycle, all
// MAX_VERTICES of them, with s_tready low.
// cfg_ready is always high; write it only while no request is outstanding.
`default_nettype none

module adjacency_matrix_degree_tracker
    import amdt_pkg::*;
#(
    parameter int MAX_VERTICES = 128
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // src_vertex[7:0], dst_vertex[15:8]
    input  wire logic [0:0]           s_tuser,   // action[0]
    // response stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // edge_was_present[0], in_degree[8:1],
                                                 // out_degree[16:9], zero[23:17]
    output logic      [0:0]           m_tuser,   // status[0]
    // vertex count write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [VERTEX_W-1:0]  cfg_data
);

    localparam int IDXW = $clog2(MAX_VERTICES);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(MAX_VERTICES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDXW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [VERTEX_W-1:0]     vcount_reg, vcount_next;
    item_t                   item_reg, item_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;
    logic                    m_user_reg, m_user_next;

    logic                    cfg_fire;
    logic                    s_fire;
    logic                    complete;
    logic                    clearing;

    logic                    in_action;
    logic [VERTEX_W-1:0]     in_src;
    logic [VERTEX_W-1:0]     in_dst;
    logic                    src_ok;
    logic                    dst_ok;
    item_t                   in_item;

    logic [IDXW-1:0]         s_idx;
    logic [IDXW-1:0]         d_idx;
    logic [IDXW-1:0]         in_s_idx;
    logic [IDXW-1:0]         in_d_idx;

    logic [MAX_VERTICES-1:0] row_rdata;
    logic [MAX_VERTICES-1:0] row_mask;
    logic [MAX_VERTICES-1:0] row_wdata;
    logic [COUNT_W-1:0]      in_cnt_rdata;
    logic [COUNT_W-1:0]      out_cnt_rdata;
    logic [COUNT_W-1:0]      in_cnt_wdata;
    logic [COUNT_W-1:0]      out_cnt_wdata;
    logic                    edge_present;
    logic                    do_update;

    logic                    ram_we;
    logic [IDXW-1:0]         row_waddr;
    logic [IDXW-1:0]         in_cnt_waddr;
    logic [IDXW-1:0]         out_cnt_waddr;
    logic [IDXW-1:0]         in_cnt_raddr;

    // request field unpacking
    assign in_action = s_tuser[0];
    assign in_src    = s_tdata[VERTEX_W-1:0];
    assign in_dst    = s_tdata[2*VERTEX_W-1:VERTEX_W];

    // range checks against min(vertex_count, MAX_VERTICES)
    assign src_ok = (in_src != '0) && (in_src <= vcount_reg)
                    && (32'(in_src) <= 32'(MAX_VERTICES));
    assign dst_ok = (in_dst != '0) && (in_dst <= vcount_reg)
                    && (32'(in_dst) <= 32'(MAX_VERTICES));

    always_comb
    begin
        in_item.action = in_action;
        in_item.ok     = src_ok && ((in_action == ACT_QUERY) || dst_ok);
        in_item.src_m1 = in_src - VERTEX_W'(1);
        in_item.dst_m1 = in_dst - VERTEX_W'(1);
    end

    assign in_s_idx = IDXW'(in_item.src_m1);
    assign in_d_idx = IDXW'(in_item.dst_m1);
    assign s_idx    = IDXW'(item_reg.src_m1);
    assign d_idx    = IDXW'(item_reg.dst_m1);

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign complete  = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
    assign clearing  = (state_reg == ST_CLEAR);

    // read-modify-write of the edge row and both counters
    assign row_mask      = MAX_VERTICES'(1) << d_idx;
    assign edge_present  = |(row_rdata & row_mask);
    assign do_update     = complete && item_reg.ok && (item_reg.action == ACT_INSERT)
                           && !edge_present;
    assign ram_we        = clearing || do_update;
    assign row_waddr     = clearing ? clr_cnt_reg : s_idx;
    assign out_cnt_waddr = clearing ? clr_cnt_reg : s_idx;
    assign in_cnt_waddr  = clearing ? clr_cnt_reg : d_idx;
    assign row_wdata     = clearing ? '0 : (row_rdata | row_mask);
    assign out_cnt_wdata = clearing ? '0 :
                           ((out_cnt_rdata == COUNT_LIMIT) ? out_cnt_rdata
                                                           : out_cnt_rdata + COUNT_W'(1));
    assign in_cnt_wdata  = clearing ? '0 :
                           ((in_cnt_rdata == COUNT_LIMIT) ? in_cnt_rdata
                                                          : in_cnt_rdata + COUNT_W'(1));

    // in-degree of dst for an insert, of src for a query
    assign in_cnt_raddr = (in_action == ACT_INSERT) ? in_d_idx : in_s_idx;

    amdt_edge_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES)
    ) u_edge_ram (
        .clk   (clk),
        .re    (s_fire),
        .raddr (in_s_idx),
        .rdata (row_rdata),
        .we    (ram_we),
        .waddr (row_waddr),
        .wdata (row_wdata)
    );

    amdt_count_ram #(
        .DEPTH (MAX_VERTICES)
    ) u_out_cnt_ram (
        .clk   (clk),
        .re    (s_fire),
        .raddr (in_s_idx),
        .rdata (out_cnt_rdata),
        .we    (ram_we),
        .waddr (out_cnt_waddr),
        .wdata (out_cnt_wdata)
    );

    amdt_count_ram #(
        .DEPTH (MAX_VERTICES)
    ) u_in_cnt_ram (
        .clk   (clk),
        .re    (s_fire),
        .raddr (in_cnt_raddr),
        .rdata (in_cnt_rdata),
        .we    (ram_we),
        .waddr (in_cnt_waddr),
        .wdata (in_cnt_wdata)
    );

    // control sequencing and response register
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        vcount_next  = vcount_reg;
        item_next    = item_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + IDXW'(1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    item_next  = in_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (complete)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_user_next  = item_reg.ok ? STATUS_OK : STATUS_RANGE;
                    if (item_reg.ok)
                    begin
                        if (item_reg.action == ACT_INSERT)
                        begin
                            m_data_next[0] = edge_present;
                        end
                        else
                        begin
                            m_data_next[COUNT_W:1]           = in_cnt_rdata;
                            m_data_next[2*COUNT_W:COUNT_W+1] = out_cnt_rdata;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // a new vertex count starts a new graph
        if (cfg_fire)
        begin
            vcount_next  = cfg_data;
            clr_cnt_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            vcount_reg  <= VERTEX_COUNT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            vcount_reg  <= vcount_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

`default_nettype wire
